@@ hdl/bbd_pkg.sv @@
// bbd_pkg: constants, types and arithmetic helpers for the bayer demosaic block
// no dependencies; used by every other file of the block
package bbd_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int SAMPLE_BITS    = 10;
    localparam int ADDR_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
    localparam int DIM_BITS       = 13;
    localparam int LEVEL_BITS     = 14;
    localparam int SUM_BITS       = SAMPLE_BITS + 2;
    localparam int SCALED_BITS    = SUM_BITS + 4;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(3280);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(2464);
    localparam logic [DIM_BITS-1:0] DIM_MIN      = DIM_BITS'(2);
    localparam logic [DIM_BITS-1:0] WIDTH_MAX    = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0] HEIGHT_MAX   = DIM_BITS'(MAX_HEIGHT);

    // reciprocal of three, exact for any dividend below 2**(RECIP_SHIFT-1)
    localparam int RECIP_SHIFT = SCALED_BITS + 1;
    localparam logic [RECIP_SHIFT-1:0] RECIP3 =
        RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic [1:0] SLOT_LAST = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic       advance;
        logic [1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic [3:0] emit_mask;
        logic       out_free;
    } t_stat;

    // floor(sum * 16 / count) for a neighbor count of one to four
    function automatic logic [LEVEL_BITS-1:0] mean16(input logic [SUM_BITS-1:0] sum,
                                                     input logic [2:0] cnt);
        logic [SCALED_BITS-1:0]             scaled;
        logic [SCALED_BITS+RECIP_SHIFT-1:0] prod;
        logic [LEVEL_BITS-1:0]              res;
        scaled = {sum, 4'b0000};
        prod   = scaled * RECIP3;
        unique case (cnt)
            3'd1:    res = LEVEL_BITS'(scaled);
            3'd2:    res = LEVEL_BITS'(scaled >> 1);
            3'd3:    res = LEVEL_BITS'(prod >> RECIP_SHIFT);
            3'd4:    res = LEVEL_BITS'(scaled >> 2);
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

@@ hdl/bbd_if.sv @@
// bbd interfaces: sample input, color output and register write channels
// depends on bbd_pkg for field widths
interface bbd_in_if;
    logic                            valid;
    logic                            ready;
    logic [bbd_pkg::SAMPLE_BITS-1:0] raw_sample;
    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface bbd_out_if;
    logic                           valid;
    logic                           ready;
    logic [bbd_pkg::LEVEL_BITS-1:0] red_level;
    logic [bbd_pkg::LEVEL_BITS-1:0] green_level;
    logic [bbd_pkg::LEVEL_BITS-1:0] blue_level;
    logic                           row_end;
    logic                           frame_end;
    logic                           run_last;
    modport source (output valid, output red_level, output green_level, output blue_level,
                    output row_end, output frame_end, output run_last, input ready);
    modport sink   (input valid, input red_level, input green_level, input blue_level,
                    input row_end, input frame_end, input run_last, output ready);
endinterface

interface bbd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bbd_pkg::CFG_INDEX_BITS-1:0] index;
    logic [bbd_pkg::DIM_BITS-1:0]       data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/bbd_datapath.sv @@
// bbd_datapath: line stores, 3x3 window, position counters, color math, output register
// depends on bbd_pkg and bbd_if
module bbd_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_pix_xfer,
    input  logic [bbd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                            i_cfg_xfer,
    input  logic [bbd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [bbd_pkg::DIM_BITS-1:0]    i_cfg_data,
    input  bbd_pkg::t_cmd                   i_cmd,
    output bbd_pkg::t_stat                  o_stat,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [bbd_pkg::LEVEL_BITS-1:0]  o_red,
    output logic [bbd_pkg::LEVEL_BITS-1:0]  o_green,
    output logic [bbd_pkg::LEVEL_BITS-1:0]  o_blue,
    output logic                            o_row_end,
    output logic                            o_frame_end,
    output logic                            o_run_last
);
    localparam int SB = bbd_pkg::SAMPLE_BITS;
    localparam int LB = bbd_pkg::LEVEL_BITS;
    localparam int DB = bbd_pkg::DIM_BITS;

    logic [SB-1:0] r_older_mem [bbd_pkg::MAX_WIDTH];
    logic [SB-1:0] r_newer_mem [bbd_pkg::MAX_WIDTH];
    logic [SB-1:0] r_older_rd, r_newer_rd, r_sample;
    logic [SB-1:0] r_win [3][3];

    logic [DB-1:0] r_width, r_height;
    logic [bbd_pkg::ADDR_BITS-1:0] r_col;
    logic [bbd_pkg::ROW_BITS-1:0]  r_row;

    logic          r_out_valid;
    logic [LB-1:0] r_red, r_green, r_blue;
    logic          r_row_end, r_frame_end, r_run_last;

    logic [DB-1:0] eff_w, eff_h;
    logic          last_col, last_row, x_ge1, x_ge2, y_ge1, y_ge2;
    logic [3:0]    mask;

    // memory read at the sample transfer, write in the load cycle that follows
    always_ff @(posedge i_clk) begin
        if (i_pix_xfer) begin
            r_older_rd <= r_older_mem[r_col];
            r_newer_rd <= r_newer_mem[r_col];
            r_sample   <= i_sample;
        end
        if (i_cmd.load) begin
            r_older_mem[r_col] <= r_newer_rd;
            r_newer_mem[r_col] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_older_rd;
            r_win[1][2] <= r_newer_rd;
            r_win[2][2] <= r_sample;
        end
    end

    always_comb begin
        if (r_width < bbd_pkg::DIM_MIN)          eff_w = bbd_pkg::DIM_MIN;
        else if (r_width > bbd_pkg::WIDTH_MAX)   eff_w = bbd_pkg::WIDTH_MAX;
        else                                     eff_w = r_width;
        if (r_height < bbd_pkg::DIM_MIN)         eff_h = bbd_pkg::DIM_MIN;
        else if (r_height > bbd_pkg::HEIGHT_MAX) eff_h = bbd_pkg::HEIGHT_MAX;
        else                                     eff_h = r_height;
    end

    assign last_col = (DB'(r_col) + DB'(1)) >= eff_w;
    assign last_row = (DB'(r_row) + DB'(1)) >= eff_h;
    assign x_ge1    = r_col != '0;
    assign x_ge2    = r_col > bbd_pkg::ADDR_BITS'(1);
    assign y_ge1    = r_row != '0;
    assign y_ge2    = r_row > bbd_pkg::ROW_BITS'(1);
    assign mask     = {last_row & last_col, last_row & x_ge1,
                       y_ge1 & last_col, y_ge1 & x_ge1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bbd_pkg::WIDTH_RESET;
            r_height <= bbd_pkg::HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_xfer) begin
            unique case (i_cfg_index)
                bbd_pkg::REG_FRAME_WIDTH: begin
                    r_width <= i_cfg_data;
                    r_col   <= '0;
                    r_row   <= '0;
                end
                bbd_pkg::REG_FRAME_HEIGHT: begin
                    r_height <= i_cfg_data;
                    r_col    <= '0;
                    r_row    <= '0;
                end
                default: ;
            endcase
        end else if (i_cmd.advance) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // neighborhood of the site picked by the slot
    logic          rb, cb, up, dn, lf, rt, yodd, xodd, run_last;
    logic [1:0]    lc, mc;
    logic [SB-1:0] tl, tm, tr, ml, mm, mr, bl, bm, br;
    logic [bbd_pkg::SUM_BITS-1:0] hs, vs, ds, hvs;
    logic [2:0]    hc, vc, dcnt, hvc;
    logic [LB-1:0] own, m_hv, m_h, m_v, m_d;
    logic [LB-1:0] n_red, n_green, n_blue;

    always_comb begin
        rb = i_cmd.slot[1];
        cb = i_cmd.slot[0];
        lc = {1'b0, cb};
        mc = lc + 2'd1;
        up = rb ? y_ge1 : y_ge2;
        dn = !rb;
        lf = cb ? x_ge1 : x_ge2;
        rt = !cb;
        yodd = rb ? r_row[0] : ~r_row[0];
        xodd = cb ? r_col[0] : ~r_col[0];
        tl = rb ? r_win[1][lc] : r_win[0][lc];
        tm = rb ? r_win[1][mc] : r_win[0][mc];
        tr = rb ? r_win[1][2] : r_win[0][2];
        ml = rb ? r_win[2][lc] : r_win[1][lc];
        mm = rb ? r_win[2][mc] : r_win[1][mc];
        mr = rb ? r_win[2][2] : r_win[1][2];
        bl = r_win[2][lc];
        bm = r_win[2][mc];
        br = r_win[2][2];
        hs = (lf ? 12'(ml) : '0) + (rt ? 12'(mr) : '0);
        hc = 3'(lf) + 3'(rt);
        vs = (up ? 12'(tm) : '0) + (dn ? 12'(bm) : '0);
        vc = 3'(up) + 3'(dn);
        ds = ((up && lf) ? 12'(tl) : '0) + ((up && rt) ? 12'(tr) : '0)
           + ((dn && lf) ? 12'(bl) : '0) + ((dn && rt) ? 12'(br) : '0);
        dcnt = 3'(up && lf) + 3'(up && rt) + 3'(dn && lf) + 3'(dn && rt);
        hvs  = hs + vs;
        hvc  = hc + vc;
        own  = {mm, 4'b0000};
        m_hv = bbd_pkg::mean16(hvs, hvc);
        m_h  = bbd_pkg::mean16(hs, hc);
        m_v  = bbd_pkg::mean16(vs, vc);
        m_d  = bbd_pkg::mean16(ds, dcnt);
        unique case ({yodd, xodd})
            2'b00: begin n_blue = own; n_green = m_hv; n_red = m_d; end
            2'b11: begin n_red = own; n_green = m_hv; n_blue = m_d; end
            2'b01: begin n_green = own; n_blue = m_h; n_red = m_v; end
            default: begin n_green = own; n_red = m_h; n_blue = m_v; end
        endcase
        unique case (i_cmd.slot)
            2'd0:    run_last = mask[3:1] == '0;
            2'd1:    run_last = mask[3:2] == '0;
            2'd2:    run_last = !mask[3];
            default: run_last = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_red       <= n_red;
            r_green     <= n_green;
            r_blue      <= n_blue;
            r_row_end   <= cb;
            r_frame_end <= i_cmd.slot == bbd_pkg::SLOT_LAST;
            r_run_last  <= run_last;
        end
    end

    assign o_stat.emit_mask = mask;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;
    assign o_run_last  = r_run_last;

endmodule

@@ hdl/bbd_ctrl.sv @@
// bbd_ctrl: sequencer that loads one sample then walks the four result slots
// depends on bbd_pkg
module bbd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pix_xfer,
    input  bbd_pkg::t_stat i_stat,
    output bbd_pkg::t_cmd  o_cmd,
    output logic           o_idle
);
    bbd_pkg::t_state r_state, n_state;
    logic [1:0]      r_slot, n_slot;
    logic            step;

    assign step = !i_stat.emit_mask[r_slot] || i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbd_pkg::S_IDLE;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        unique case (r_state)
            bbd_pkg::S_IDLE: begin
                n_slot = '0;
                if (i_pix_xfer) n_state = bbd_pkg::S_LOAD;
            end
            bbd_pkg::S_LOAD: begin
                n_state = bbd_pkg::S_EMIT;
            end
            bbd_pkg::S_EMIT: begin
                if (step) begin
                    n_slot = r_slot + 1'b1;
                    if (r_slot == bbd_pkg::SLOT_LAST) n_state = bbd_pkg::S_IDLE;
                end
            end
            default: n_state = bbd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load    = r_state == bbd_pkg::S_LOAD;
        o_cmd.emit    = (r_state == bbd_pkg::S_EMIT) && i_stat.emit_mask[r_slot]
                        && i_stat.out_free;
        o_cmd.advance = (r_state == bbd_pkg::S_EMIT) && step
                        && (r_slot == bbd_pkg::SLOT_LAST);
        o_cmd.slot    = r_slot;
        o_idle        = r_state == bbd_pkg::S_IDLE;
    end

endmodule

@@ hdl/bayer_bilinear_demosaic_top.sv @@
// bayer_bilinear_demosaic_top: bilinear demosaic of a BGGR raw stream into 10.4 rgb
// depends on bbd_pkg, bbd_if, bbd_ctrl and bbd_datapath
//
// Raw samples enter in raster order (blue at even row and column, red at odd row and
// column) and leave as red, green and blue in unsigned 10.4 fixed point. Each missing
// color is the floor of the mean of the neighbors inside the frame, so border pixels
// average fewer samples. Two line stores of 4096 samples hold the rows above; row y
// leaves while row y+1 enters, and the last row leaves together with its own input.
// One sample is handled at a time: the transfer cycle reads both line stores, the next
// cycle writes them back and shifts the 3x3 window, then the four result slots (zero to
// four results) in turn build a result into the output register, a slot with a result
// waiting while it is full; the next sample is taken after the last slot. The output
// register lets the last result wait while the next sample is taken. A register write
// restarts the frame at row zero, column zero; write registers only while idle.
module bayer_bilinear_demosaic_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbd_in_if.sink    i_pixel,
    bbd_out_if.source o_result,
    bbd_cfg_if.sink   i_cfg
);
    bbd_pkg::t_cmd  cmd;
    bbd_pkg::t_stat stat;
    logic           idle;
    logic           pix_xfer;
    logic           cfg_xfer;

    // both channels are taken only between samples; a pending register write goes first
    assign i_pixel.ready = idle && !i_cfg.valid;
    assign i_cfg.ready   = idle;
    assign pix_xfer      = i_pixel.valid && i_pixel.ready;
    assign cfg_xfer      = i_cfg.valid && i_cfg.ready;

    bbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix_xfer (pix_xfer),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    bbd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_xfer  (pix_xfer),
        .i_sample    (i_pixel.raw_sample),
        .i_cfg_xfer  (cfg_xfer),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_red       (o_result.red_level),
        .o_green     (o_result.green_level),
        .o_blue      (o_result.blue_level),
        .o_row_end   (o_result.row_end),
        .o_frame_end (o_result.frame_end),
        .o_run_last  (o_result.run_last)
    );

`ifndef NO_ASSERTIONS
    // a sample transfer is followed by the load cycle, never by another transfer
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_xfer |=> !i_pixel.ready)
        else $error("sample taken during load");

    // the last pixel of a frame is also the last of its row and of its run
    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.frame_end |-> o_result.row_end && o_result.run_last)
        else $error("frame end without row end");

    // a result is never built while the output register holds an untaken one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !o_result.valid || o_result.ready)
        else $error("output overwritten");
`endif

endmodule

@@ dv/tb_bayer_bilinear_demosaic_top.sv @@
// tb_bayer_bilinear_demosaic_top: self-checking bench for the bilinear bayer demosaic
// depends on bbd_pkg, the bbd interfaces and bayer_bilinear_demosaic_top
`timescale 1ns / 100ps

module tb_bayer_bilinear_demosaic_top;

    // index that maps to no register, writes to it must change nothing
    localparam logic [bbd_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED =
        bbd_pkg::CFG_INDEX_BITS'(2);

    typedef logic [bbd_pkg::SAMPLE_BITS-1:0] t_sample;
    typedef logic [bbd_pkg::LEVEL_BITS-1:0]  t_level;

    typedef struct {
        t_level red;
        t_level green;
        t_level blue;
        logic   row_end;
        logic   frame_end;
        logic   run_last;
    } t_rgb_pixel;

    logic i_clk;
    logic i_rst_n;

    bbd_in_if  pix_ch ();
    bbd_out_if rgb_ch ();
    bbd_cfg_if cfg_ch ();

    bayer_bilinear_demosaic_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pixel  (pix_ch),
        .o_result (rgb_ch),
        .i_cfg    (cfg_ch)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------
    // demosaic predictor: own copy of line stores, window and position
    // ---------------------------------------------------------------
    t_sample     older_row [bbd_pkg::MAX_WIDTH];
    t_sample     newer_row [bbd_pkg::MAX_WIDTH];
    t_sample     win [3][3];
    int          col_pos;
    int          row_pos;
    int          width_reg;
    int          height_reg;

    t_sample     raw_pending [$];   // samples waiting for the input transfer
    t_rgb_pixel  rgb_expected [$];  // predicted colors, oldest first
    int          err_count;
    bit          no_gaps;           // stretch with no idling on either side

    function automatic t_level avg16(input int sum, input int cnt);
        if (cnt == 0) return '0;
        return t_level'((sum * 16) / cnt);
    endfunction

    // colors of the site centered on window cell (rc, cc)
    function automatic t_rgb_pixel site_colors(input int rc, input int cc, input int oy,
                                               input int ox, input bit up, input bit down,
                                               input bit left, input bit right,
                                               input bit rend, input bit fend);
        t_rgb_pixel p;
        int   nb [3][3];
        bit   ok [3][3];
        int   r, c, hs, hc, vs, vc, ds, dn;
        t_level own;
        hs = 0; hc = 0; vs = 0; vc = 0; ds = 0; dn = 0;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                r = rc - 1 + dr;
                c = cc - 1 + dc;
                ok[dr][dc] = (r >= 0 && r <= 2 && c >= 0 && c <= 2);
                if (dr == 0 && !up) ok[dr][dc] = 0;
                if (dr == 2 && !down) ok[dr][dc] = 0;
                if (dc == 0 && !left) ok[dr][dc] = 0;
                if (dc == 2 && !right) ok[dr][dc] = 0;
                nb[dr][dc] = ok[dr][dc] ? int'(win[r][c]) : 0;
            end
        end
        own = t_level'(nb[1][1] * 16);
        if (ok[1][0]) begin hs += nb[1][0]; hc++; end
        if (ok[1][2]) begin hs += nb[1][2]; hc++; end
        if (ok[0][1]) begin vs += nb[0][1]; vc++; end
        if (ok[2][1]) begin vs += nb[2][1]; vc++; end
        if (ok[0][0]) begin ds += nb[0][0]; dn++; end
        if (ok[0][2]) begin ds += nb[0][2]; dn++; end
        if (ok[2][0]) begin ds += nb[2][0]; dn++; end
        if (ok[2][2]) begin ds += nb[2][2]; dn++; end
        if (oy % 2 == 0 && ox % 2 == 0) begin
            // blue site
            p.blue = own; p.green = avg16(hs + vs, hc + vc); p.red = avg16(ds, dn);
        end else if (oy % 2 == 1 && ox % 2 == 1) begin
            // red site
            p.red = own; p.green = avg16(hs + vs, hc + vc); p.blue = avg16(ds, dn);
        end else if (oy % 2 == 0) begin
            // green on a blue row
            p.green = own; p.blue = avg16(hs, hc); p.red = avg16(vs, vc);
        end else begin
            // green on a red row
            p.green = own; p.red = avg16(hs, hc); p.blue = avg16(vs, vc);
        end
        p.row_end   = rend;
        p.frame_end = fend;
        p.run_last  = 1'b0;
        return p;
    endfunction

    // advance the predictor by one sample, queue the colors it releases
    task automatic predict_demosaic(input t_sample s);
        t_rgb_pixel outs [4];
        int  w, h, x, y, n;
        bit  lastc, lastr;
        w = (width_reg < 2) ? 2 :
            (width_reg > bbd_pkg::MAX_WIDTH ? bbd_pkg::MAX_WIDTH : width_reg);
        h = (height_reg < 2) ? 2 :
            (height_reg > bbd_pkg::MAX_HEIGHT ? bbd_pkg::MAX_HEIGHT : height_reg);
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        n = 0;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = older_row[x];
        win[1][2] = newer_row[x];
        win[2][2] = s;
        older_row[x] = newer_row[x];
        newer_row[x] = s;
        lastc = (x + 1 >= w);
        lastr = (y + 1 >= h);
        // row above the incoming one
        if (y >= 1) begin
            if (x >= 1)
                outs[n++] = site_colors(1, 1, y - 1, x - 1, y >= 2, 1, x >= 2, 1, 0, 0);
            if (lastc)
                outs[n++] = site_colors(1, 2, y - 1, x, y >= 2, 1, x >= 1, 0, 1, 0);
        end
        // last row leaves with its own input
        if (lastr) begin
            if (x >= 1)
                outs[n++] = site_colors(2, 1, y, x - 1, y >= 1, 0, x >= 2, 1, 0, 0);
            if (lastc)
                outs[n++] = site_colors(2, 2, y, x, y >= 1, 0, x >= 1, 0, 1, 1);
        end
        if (n > 0) outs[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++) rgb_expected = {rgb_expected, outs[i]};
        if (lastc) begin
            col_pos = 0;
            row_pos = lastr ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (no_gaps) return 0;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ---------------------------------------------------------------
    // sample driver: inputs change on the falling edge
    // ---------------------------------------------------------------
    int pix_gap;

    always @(posedge i_clk) begin
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            predict_demosaic(pix_ch.raw_sample);
            void'(raw_pending.pop_front());
            pix_gap = pick_gap();
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || raw_pending.size() == 0) begin
            pix_ch.valid <= 1'b0;
        end else if (pix_gap > 0) begin
            pix_gap--;
            pix_ch.valid <= 1'b0;
        end else begin
            pix_ch.valid      <= 1'b1;
            pix_ch.raw_sample <= raw_pending[0];
        end
    end

    // ---------------------------------------------------------------
    // color monitor: ready toggles on the falling edge, checks on the rising edge
    // ---------------------------------------------------------------
    int rgb_stall;

    always @(negedge i_clk) begin
        if (rgb_stall > 0) begin
            rgb_stall--;
            rgb_ch.ready <= 1'b0;
        end else begin
            rgb_ch.ready <= 1'b1;
            rgb_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (i_rst_n && rgb_ch.valid && rgb_ch.ready) begin
            if (rgb_expected.size() == 0) begin
                $display("%0t: unexpected transfer r=%0d g=%0d b=%0d", $time,
                         rgb_ch.red_level, rgb_ch.green_level, rgb_ch.blue_level);
                err_count++;
            end else begin
                want = rgb_expected.pop_front();
                if (rgb_ch.red_level !== want.red || rgb_ch.green_level !== want.green ||
                    rgb_ch.blue_level !== want.blue || rgb_ch.row_end !== want.row_end ||
                    rgb_ch.frame_end !== want.frame_end ||
                    rgb_ch.run_last !== want.run_last) begin
                    $display("%0t: expected r=%0d g=%0d b=%0d re=%0b fe=%0b rl=%0b",
                             $time, want.red, want.green, want.blue, want.row_end,
                             want.frame_end, want.run_last);
                    $display("%0t:   actual r=%0d g=%0d b=%0d re=%0b fe=%0b rl=%0b",
                             $time, rgb_ch.red_level, rgb_ch.green_level,
                             rgb_ch.blue_level, rgb_ch.row_end, rgb_ch.frame_end,
                             rgb_ch.run_last);
                    err_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // sequencing
    // ---------------------------------------------------------------

    // one register transfer; the predictor follows at the same edge
    task automatic write_reg(input logic [bbd_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [bbd_pkg::DIM_BITS-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == bbd_pkg::REG_FRAME_WIDTH || idx == bbd_pkg::REG_FRAME_HEIGHT) begin
            if (idx == bbd_pkg::REG_FRAME_WIDTH) width_reg = int'(value);
            else height_reg = int'(value);
            col_pos = 0;
            row_pos = 0;
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // block idle: nothing queued, nothing expected, plus slack for the slot pipeline
    task automatic drain();
        while (raw_pending.size() != 0 || rgb_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // fill: 0 random, 1 all full scale, 2 all zero, 3 checkerboard of extremes
    task automatic queue_frame(input int w, input int h, input int fill);
        t_sample s;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                case (fill)
                    1:       s = '1;
                    2:       s = '0;
                    3:       s = ((x + y) % 2 == 0) ? '1 : '0;
                    default: s = t_sample'($urandom);
                endcase
                raw_pending = {raw_pending, s};
            end
        end
    endtask

    task automatic run_frame(input logic [bbd_pkg::DIM_BITS-1:0] w,
                             input logic [bbd_pkg::DIM_BITS-1:0] h, input int fill);
        int ew, eh;
        write_reg(bbd_pkg::REG_FRAME_WIDTH, w);
        write_reg(bbd_pkg::REG_FRAME_HEIGHT, h);
        ew = (w < 2) ? 2 : (w > bbd_pkg::MAX_WIDTH ? bbd_pkg::MAX_WIDTH : int'(w));
        eh = (h < 2) ? 2 : (h > bbd_pkg::MAX_HEIGHT ? bbd_pkg::MAX_HEIGHT : int'(h));
        queue_frame(ew, eh, fill);
        drain();
    endtask

    initial begin
        int sent;
        int fw, fh;
        i_rst_n           = 1'b0;
        pix_ch.valid      = 1'b0;
        pix_ch.raw_sample = '0;
        rgb_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = bbd_pkg::REG_FRAME_WIDTH;
        cfg_ch.data       = '0;
        pix_gap    = 0;
        rgb_stall  = 0;
        err_count  = 0;
        no_gaps    = 0;
        width_reg  = int'(bbd_pkg::WIDTH_RESET);
        height_reg = int'(bbd_pkg::HEIGHT_RESET);
        col_pos    = 0;
        row_pos    = 0;
        for (int i = 0; i < bbd_pkg::MAX_WIDTH; i++) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) win[r][c] = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset geometry: part of row zero, which releases nothing
        queue_frame(6, 1, 0);
        drain();

        // directed: smallest frames, clamped sizes, extreme samples
        run_frame(2, 2, 1);
        run_frame(0, 1, 3);
        write_reg(REG_UNMAPPED, '1);
        run_frame(3, 3, 3);
        run_frame(2, 3, 2);

        // random small frames, with idle and no-idle stretches picked at random
        sent = 0;
        while (sent < 200) begin
            no_gaps = ($urandom_range(3) == 0);
            fw = $urandom_range(2, 9);
            fh = $urandom_range(2, 6);
            run_frame(bbd_pkg::DIM_BITS'(fw), bbd_pkg::DIM_BITS'(fh),
                      ($urandom_range(9) == 0) ? 3 : 0);
            sent += fw * fh;
        end

        no_gaps = 0;
        run_frame(5, 4, 0);

        drain();
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end

endmodule
